// ===== rtl/bcad_pkg.sv =====
// Shared types, codes and helpers for the BC alpha block decoder.
package bcad_pkg;

   localparam logic [1:0] MODE_RAW = 2'd0;
   localparam logic [1:0] MODE_BC1 = 2'd1;
   localparam logic [1:0] MODE_BC2 = 2'd2;
   localparam logic [1:0] MODE_BC3 = 2'd3;

   localparam logic CSR_FORMAT_MODE = 1'b0;
   localparam logic CSR_ALPHA_MASK  = 1'b1;

   // divisor select carried with each pixel through the divider stages
   localparam logic [1:0] DSEL_NONE = 2'd0;
   localparam logic [1:0] DSEL_MASK = 2'd1;
   localparam logic [1:0] DSEL_7    = 2'd2;
   localparam logic [1:0] DSEL_5    = 2'd3;

   localparam logic [2:0] BC3_DIV_HI = 3'd7;
   localparam logic [2:0] BC3_DIV_LO = 3'd5;

   localparam int QUOT_BITS = 8;
   localparam int REM_BITS  = 40;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  pos;
      logic        last;
      logic [3:0]  code;
      logic [7:0]  a0;
      logic [7:0]  a1;
      logic        c0le;
      logic [31:0] pixel;
   } pix_type;

   typedef struct packed {
      logic                  last;
      logic [3:0]            pos;
      logic [1:0]            dsel;
      logic [REM_BITS-1:0]   rem;
      logic [QUOT_BITS-1:0]  alpha;
   } stage_type;

   // highest row/column index for an extent of 1..4, larger extents clamp to 4
   function automatic logic [1:0] extent_max(input logic [2:0] v);
      logic [1:0] m;
      m = v[2] ? 2'd3 : (v[1:0] - 2'd1);
      return m;
   endfunction

endpackage

// ===== rtl/bc_block_alpha_decoder.sv =====
// Alpha decoder for BC1/BC2/BC3 blocks and uncompressed pixels, top level.
//
// Usage: write format_mode (index 0) and alpha_field_mask (index 1) through
// csr_we/csr_index/csr_wdata while no block is in flight. Each transfer on
// the req_ channel carries one 64-bit block word plus the block's extent
// inside the image. BC modes give one rsp_ transfer per valid pixel in
// row-major order; uncompressed mode gives exactly one. A BC block with a
// zero extent gives none. rsp_last_of_block marks the final transfer.
// Throughput: one result per cycle while the receiver does not stall; a
// block holds the sequencer until its pixels are issued, and the next block
// is taken in the cycle its predecessor issues its last pixel. The rate is
// set by the single-pixel issue of the sequencer; the 8-stage restoring
// divider that forms the alpha quotient is fully pipelined.
// Reset (synchronous) clears all valid bits and both registers to zero.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_stall rises; nothing is dropped or repeated.
module bc_block_alpha_decoder
   import bcad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_block_word,
   input  logic [2:0]  req_valid_columns,
   input  logic [2:0]  req_valid_rows,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_alpha_value,
   output logic [3:0]  rsp_pixel_position,
   output logic        rsp_last_of_block
);

   logic [1:0]  format_mode_ff, format_mode_in;
   logic [31:0] alpha_mask_ff, alpha_mask_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_alpha_ff;
   logic [3:0]  rsp_pos_ff;
   logic        rsp_last_ff;
   logic        adv;
   logic        pix_vld;
   pix_type     pix;
   logic        pipe_vld [0:QUOT_BITS];
   stage_type   pipe_st  [0:QUOT_BITS];

   always_comb begin
      format_mode_in = format_mode_ff;
      alpha_mask_in  = alpha_mask_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FORMAT_MODE: format_mode_in = csr_wdata[1:0];
            CSR_ALPHA_MASK:  alpha_mask_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_mode_ff <= MODE_RAW;
         alpha_mask_ff  <= 32'd0;
      end else begin
         format_mode_ff <= format_mode_in;
         alpha_mask_ff  <= alpha_mask_in;
      end
   end

   // pipeline moves whenever the output register is free or being drained
   assign adv = !rsp_valid_ff || !rsp_stall;

   bcad_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .adv               (adv),
      .mode              (format_mode_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_block_word    (req_block_word),
      .req_valid_columns (req_valid_columns),
      .req_valid_rows    (req_valid_rows),
      .pix_vld           (pix_vld),
      .pix               (pix)
   );

   bcad_prep u_prep (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .mask    (alpha_mask_ff),
      .pix_vld (pix_vld),
      .pix     (pix),
      .st_vld  (pipe_vld[0]),
      .st      (pipe_st[0])
   );

   for (genvar g = 0; g < QUOT_BITS; g++) begin : g_div
      bcad_div_step #(
         .BIT_POS (QUOT_BITS - 1 - g)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .mask    (alpha_mask_ff),
         .in_vld  (pipe_vld[g]),
         .in_st   (pipe_st[g]),
         .out_vld (pipe_vld[g+1]),
         .out_st  (pipe_st[g+1])
      );
   end

   assign rsp_valid_in = pipe_vld[QUOT_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_alpha_ff <= pipe_st[QUOT_BITS].alpha;
         rsp_pos_ff   <= pipe_st[QUOT_BITS].pos;
         rsp_last_ff  <= pipe_st[QUOT_BITS].last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_alpha_value    = rsp_alpha_ff;
   assign rsp_pixel_position = rsp_pos_ff;
   assign rsp_last_of_block  = rsp_last_ff;

   a_frozen_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while pipeline is frozen");

   a_frozen_holds_tail: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(pipe_vld[QUOT_BITS]))
      else $error("last pipeline stage moved while frozen");

   a_bc3_div7_rem: assert property (@(posedge clock) disable iff (reset)
      (pipe_vld[QUOT_BITS] && pipe_st[QUOT_BITS].dsel == DSEL_7) |->
         (pipe_st[QUOT_BITS].rem < 40'd7))
      else $error("BC3 divide by 7 left a remainder out of range");

   a_bc3_div5_rem: assert property (@(posedge clock) disable iff (reset)
      (pipe_vld[QUOT_BITS] && pipe_st[QUOT_BITS].dsel == DSEL_5) |->
         (pipe_st[QUOT_BITS].rem < 40'd5))
      else $error("BC3 divide by 5 left a remainder out of range");

endmodule

// ===== rtl/bcad_seq.sv =====
// Block sequencer: holds one input block and issues one pixel per cycle while the pipeline advances.
module bcad_seq
   import bcad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic [1:0]  mode,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_block_word,
   input  logic [2:0]  req_valid_columns,
   input  logic [2:0]  req_valid_rows,
   output logic        pix_vld,
   output pix_type     pix
);

   logic        busy_ff, busy_in;
   logic [63:0] word_ff, word_in;
   logic [1:0]  colmax_ff, colmax_in;
   logic [1:0]  rowmax_ff, rowmax_in;
   logic [1:0]  row_ff, row_in;
   logic [1:0]  col_ff, col_in;
   logic        pix_vld_ff, pix_vld_in;
   pix_type     pix_ff, pix_in;

   logic        issue_last;
   logic        take;
   logic        empty;
   logic [3:0]  pos;
   logic [5:0]  sh_bc1;
   logic [5:0]  sh_bc3;
   logic [63:0] w_bc1;
   logic [63:0] w_bc2;
   logic [63:0] w_bc3;

   assign issue_last = (row_ff == rowmax_ff) && (col_ff == colmax_ff);
   assign req_stall  = !adv || (busy_ff && !issue_last);
   assign take       = req_valid && !req_stall;
   assign empty      = (mode != MODE_RAW) &&
                       ((req_valid_columns == 3'd0) || (req_valid_rows == 3'd0));

   always_comb begin
      busy_in   = busy_ff;
      word_in   = word_ff;
      colmax_in = colmax_ff;
      rowmax_in = rowmax_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      if (take) begin
         busy_in   = !empty;
         word_in   = req_block_word;
         colmax_in = (mode == MODE_RAW) ? 2'd0 : extent_max(req_valid_columns);
         rowmax_in = (mode == MODE_RAW) ? 2'd0 : extent_max(req_valid_rows);
         row_in    = 2'd0;
         col_in    = 2'd0;
      end else if (busy_ff) begin
         if (issue_last) begin
            busy_in = 1'b0;
         end else if (col_ff == colmax_ff) begin
            col_in = 2'd0;
            row_in = row_ff + 2'd1;
         end else begin
            col_in = col_ff + 2'd1;
         end
      end
   end

   // per-pixel field extraction
   assign pos    = {row_ff, col_ff};
   assign sh_bc1 = {1'b1, pos, 1'b0};
   assign sh_bc3 = {1'b0, pos, 1'b0} + {2'b00, pos} + 6'd16;
   assign w_bc1  = word_ff >> sh_bc1;
   assign w_bc2  = word_ff >> {pos, 2'b00};
   assign w_bc3  = word_ff >> sh_bc3;

   always_comb begin
      pix_vld_in   = busy_ff;
      pix_in.mode  = mode;
      pix_in.pos   = (mode == MODE_RAW) ? 4'd0 : pos;
      pix_in.last  = issue_last;
      pix_in.a0    = word_ff[7:0];
      pix_in.a1    = word_ff[15:8];
      pix_in.c0le  = word_ff[15:0] <= word_ff[31:16];
      pix_in.pixel = word_ff[31:0];
      unique case (mode)
         MODE_BC1: pix_in.code = {2'b00, w_bc1[1:0]};
         MODE_BC2: pix_in.code = w_bc2[3:0];
         MODE_BC3: pix_in.code = {1'b0, w_bc3[2:0]};
         default:  pix_in.code = 4'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         pix_vld_ff <= 1'b0;
      end else if (adv) begin
         busy_ff    <= busy_in;
         pix_vld_ff <= pix_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         word_ff   <= word_in;
         colmax_ff <= colmax_in;
         rowmax_ff <= rowmax_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         pix_ff    <= pix_in;
      end
   end

   assign pix_vld = pix_vld_ff;
   assign pix     = pix_ff;

endmodule

// ===== rtl/bcad_prep.sv =====
// Prepare stage: direct alphas, BC3 weighted sum and uncompressed dividend.
module bcad_prep
   import bcad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic [31:0] mask,
   input  logic        pix_vld,
   input  pix_type     pix,
   output logic        st_vld,
   output stage_type   st
);

   logic        st_vld_ff;
   stage_type   st_ff, st_in;

   logic [2:0]          sel;
   logic                gt;
   logic [2:0]          wa;
   logic [2:0]          wb;
   logic [3:0]          wa_full;
   logic [10:0]         xa;
   logic [10:0]         xb;
   logic [10:0]         x;
   logic [REM_BITS-1:0] num;

   assign sel     = pix.code[2:0];
   assign gt      = pix.a0 > pix.a1;
   assign wa_full = gt ? (4'd8 - {1'b0, sel}) : (4'd6 - {1'b0, sel});
   assign wa      = wa_full[2:0];
   assign wb      = sel - 3'd1;
   assign xa      = {3'b000, pix.a0} * {8'd0, wa};
   assign xb      = {3'b000, pix.a1} * {8'd0, wb};
   assign x       = xa + xb;
   assign num     = {8'd0, pix.pixel & mask};

   always_comb begin
      st_in.last  = pix.last;
      st_in.pos   = pix.pos;
      st_in.dsel  = DSEL_NONE;
      st_in.rem   = '0;
      st_in.alpha = 8'd255;
      unique case (pix.mode)
         MODE_RAW: begin
            if (mask != 32'd0) begin
               st_in.dsel  = DSEL_MASK;
               st_in.rem   = (num << 8) - num;
               st_in.alpha = 8'd0;
            end
         end
         MODE_BC1: begin
            st_in.alpha = (pix.c0le && pix.code[1:0] == 2'd3) ? 8'd0 : 8'd255;
         end
         MODE_BC2: begin
            st_in.alpha = {pix.code, pix.code};
         end
         MODE_BC3: begin
            if (sel == 3'd0) begin
               st_in.alpha = pix.a0;
            end else if (sel == 3'd1) begin
               st_in.alpha = pix.a1;
            end else if (!gt && sel == 3'd6) begin
               st_in.alpha = 8'd0;
            end else if (!gt && sel == 3'd7) begin
               st_in.alpha = 8'd255;
            end else begin
               st_in.dsel  = gt ? DSEL_7 : DSEL_5;
               st_in.rem   = {{(REM_BITS-11){1'b0}}, x};
               st_in.alpha = 8'd0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_vld_ff <= 1'b0;
      end else if (adv) begin
         st_vld_ff <= pix_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign st_vld = st_vld_ff;
   assign st     = st_ff;

endmodule

// ===== rtl/bcad_div_step.sv =====
// One restoring-division stage: resolves one quotient bit of the alpha.
module bcad_div_step
   import bcad_pkg::*;
#(
   parameter int BIT_POS = 7
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic [31:0] mask,
   input  logic        in_vld,
   input  stage_type   in_st,
   output logic        out_vld,
   output stage_type   out_st
);

   logic                out_vld_ff;
   stage_type           out_st_ff, out_st_in;
   logic [REM_BITS-1:0] divisor;
   logic [REM_BITS-1:0] dsh;

   always_comb begin
      unique case (in_st.dsel)
         DSEL_MASK: divisor = {8'd0, mask};
         DSEL_7:    divisor = {{(REM_BITS-3){1'b0}}, BC3_DIV_HI};
         DSEL_5:    divisor = {{(REM_BITS-3){1'b0}}, BC3_DIV_LO};
         default:   divisor = '0;
      endcase
   end

   assign dsh = divisor << BIT_POS;

   always_comb begin
      out_st_in = in_st;
      if (in_st.dsel != DSEL_NONE && in_st.rem >= dsh) begin
         out_st_in.rem            = in_st.rem - dsh;
         out_st_in.alpha[BIT_POS] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_st_ff <= out_st_in;
      end
   end

   assign out_vld = out_vld_ff;
   assign out_st  = out_st_ff;

endmodule
